// ----- sv/cdad_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdad_pkg
// shared types, microcode program and calendar tables for the date adder
// ----------------------------------------------------------------------------
package cdad_pkg;

  localparam int YEAR_LIMIT_DEF = 9999;
  localparam int IN_YEAR_W      = 14;
  localparam int TOT_W          = 17;   // day + day count, up to 31 + 65535
  localparam int DV_W           = 9;    // divisor and remainder width
  localparam int PC_W           = 4;
  localparam int UC_DEPTH       = 14;

  localparam logic [DV_W-1:0] DIV_CENTURY = 9'd100;
  localparam logic [DV_W-1:0] DIV_CYCLE   = 9'd400;
  localparam logic [DV_W-1:0] DIV_WEEK    = 9'd7;

  // reciprocals floor(2**RCP_SH / divisor); dividends stay below 2**RCP_SH
  localparam int RCP_SH = 20;
  localparam int RCP_W  = 18;
  localparam logic [RCP_W-1:0] RCP_CENTURY = 18'd10485;
  localparam logic [RCP_W-1:0] RCP_CYCLE   = 18'd2621;
  localparam logic [RCP_W-1:0] RCP_WEEK    = 18'd149796;

  // micro-operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_Y,
    OP_SET_M400,
    OP_CHECK,
    OP_STEP,
    OP_SAT,
    OP_DIV_Z,
    OP_WSUM,
    OP_DIV_W,
    OP_PUT
  } uop_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEXT,
    C_GOTO,
    C_NO_IN,
    C_DIV_BUSY,
    C_BAD,
    C_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    cond_t            cond;
    logic [PC_W-1:0]  tgt;
    uop_t             op;
  } cw_t;

  typedef struct packed {
    uop_t op;
    logic idle;
  } ctl_t;

  typedef struct packed {
    logic div_busy;
    logic bad;
    logic more;
    logic out_busy;
  } stat_t;

  // program step addresses
  localparam logic [PC_W-1:0] PC_IDLE   = 4'd0;
  localparam logic [PC_W-1:0] PC_DIVY_W = 4'd2;
  localparam logic [PC_W-1:0] PC_STEP   = 4'd5;
  localparam logic [PC_W-1:0] PC_DIVZ_W = 4'd8;
  localparam logic [PC_W-1:0] PC_DIVW_W = 4'd11;
  localparam logic [PC_W-1:0] PC_PUT    = 4'd12;
  localparam logic [PC_W-1:0] PC_LAST   = 4'd13;

  localparam cw_t UCODE [UC_DEPTH] = '{
    '{cond: C_NO_IN,    tgt: PC_IDLE,   op: OP_LOAD},
    '{cond: C_NEXT,     tgt: PC_IDLE,   op: OP_DIV_Y},
    '{cond: C_DIV_BUSY, tgt: PC_DIVY_W, op: OP_NOP},
    '{cond: C_NEXT,     tgt: PC_IDLE,   op: OP_SET_M400},
    '{cond: C_BAD,      tgt: PC_PUT,    op: OP_CHECK},
    '{cond: C_MORE,     tgt: PC_STEP,   op: OP_STEP},
    '{cond: C_NEXT,     tgt: PC_IDLE,   op: OP_SAT},
    '{cond: C_NEXT,     tgt: PC_IDLE,   op: OP_DIV_Z},
    '{cond: C_DIV_BUSY, tgt: PC_DIVZ_W, op: OP_NOP},
    '{cond: C_NEXT,     tgt: PC_IDLE,   op: OP_WSUM},
    '{cond: C_NEXT,     tgt: PC_IDLE,   op: OP_DIV_W},
    '{cond: C_DIV_BUSY, tgt: PC_DIVW_W, op: OP_NOP},
    '{cond: C_OUT_BUSY, tgt: PC_PUT,    op: OP_PUT},
    '{cond: C_GOTO,     tgt: PC_IDLE,   op: OP_NOP}
  };

  // floor(2.6*mr - 0.2) indexed by calendar month, march is mr 1
  localparam logic [4:0] MONTH_OFS [16] = '{
    5'd0,  5'd28, 5'd31, 5'd2,  5'd5,  5'd7,  5'd10, 5'd12,
    5'd15, 5'd18, 5'd20, 5'd23, 5'd25, 5'd0,  5'd0,  5'd0
  };

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- sv/cdad_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdad_div
// divider for small constant divisors by reciprocal multiplication
// ----------------------------------------------------------------------------
module cdad_div #(
  parameter int DW = 15
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [DW-1:0]              dividend,
  input  logic [cdad_pkg::DV_W-1:0]  divisor,
  input  logic [cdad_pkg::RCP_W-1:0] recip,
  output logic                       busy,
  output logic [DW-1:0]              quo,
  output logic [cdad_pkg::DV_W-1:0]  rem
);

  localparam int PW = DW + cdad_pkg::RCP_SH;

  logic                      est_v_r;
  logic                      rem_v_r;
  logic [DW-1:0]             dvd_r;
  logic [cdad_pkg::DV_W-1:0] dvs_r;
  logic [DW-1:0]             quo_r;
  logic [DW-1:0]             rem_r;
  logic [PW-1:0]             prod;
  logic [DW-1:0]             back;
  logic                      fix;

  // estimate is the true quotient or one short
  assign prod = PW'(dividend) * PW'(recip);
  assign back = quo_r * DW'(dvs_r);
  assign fix  = rem_r >= DW'(dvs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_v_r <= 1'b0;
      rem_v_r <= 1'b0;
    end else begin
      est_v_r <= start;
      rem_v_r <= est_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      quo_r <= prod[PW-1:cdad_pkg::RCP_SH];
    end else if (est_v_r) begin
      rem_r <= dvd_r - back;
    end else if (rem_v_r && fix) begin
      // one correction step
      quo_r <= quo_r + DW'(1);
      rem_r <= rem_r - DW'(dvs_r);
    end
  end

  assign busy = est_v_r | rem_v_r;
  assign quo  = quo_r;
  assign rem  = rem_r[cdad_pkg::DV_W-1:0];

endmodule

// ----- sv/cdad_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdad_seq
// microcode sequencer: step counter, program rom and conditional jumps
// ----------------------------------------------------------------------------
module cdad_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  cdad_pkg::stat_t stat,
  output cdad_pkg::ctl_t  ctl
);

  logic [cdad_pkg::PC_W-1:0] pc_r;
  logic [cdad_pkg::PC_W-1:0] pc_nxt;
  cdad_pkg::cw_t             cw;
  logic                      jump;

  assign cw = cdad_pkg::UCODE[pc_r];

  // next step
  always_comb begin
    unique case (cw.cond)
      cdad_pkg::C_NEXT:     jump = 1'b0;
      cdad_pkg::C_GOTO:     jump = 1'b1;
      cdad_pkg::C_NO_IN:    jump = !in_valid;
      cdad_pkg::C_DIV_BUSY: jump = stat.div_busy;
      cdad_pkg::C_BAD:      jump = stat.bad;
      cdad_pkg::C_MORE:     jump = stat.more;
      cdad_pkg::C_OUT_BUSY: jump = stat.out_busy;
      default:              jump = 1'b0;
    endcase
    pc_nxt = jump ? cw.tgt : pc_r + 1'b1;
  end

  // control word to datapath
  always_comb begin
    ctl.op   = cw.op;
    ctl.idle = (pc_r == cdad_pkg::PC_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= cdad_pkg::PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= cdad_pkg::PC_LAST)
    else $error("step counter left the program");

endmodule

// ----- sv/cdad_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdad_dp
// date datapath: month stepping, leap tracking, weekday sum, output register
// ----------------------------------------------------------------------------
module cdad_dp #(
  parameter int YEAR_LIMIT = cdad_pkg::YEAR_LIMIT_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  cdad_pkg::ctl_t ctl,
  output cdad_pkg::stat_t stat,
  input  logic           in_valid,
  input  logic [13:0]    in_year,
  input  logic [3:0]     in_month,
  input  logic [4:0]     in_day,
  input  logic [15:0]    in_days_to_add,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_valid_res,
  output logic           out_overflow,
  output logic [13:0]    out_new_year,
  output logic [3:0]     out_new_month,
  output logic [4:0]     out_new_day,
  output logic [2:0]     out_weekday
);

  localparam int YW_L = $clog2(YEAR_LIMIT + 2);
  localparam int YW   = (YW_L > cdad_pkg::IN_YEAR_W) ? YW_L : cdad_pkg::IN_YEAR_W;
  localparam int DW   = YW + 1;
  localparam int TW   = cdad_pkg::TOT_W;
  localparam logic [YW-1:0] LIMIT = YW'(YEAR_LIMIT);

  logic [YW-1:0]             yr_r;
  logic [3:0]                mo_r;
  logic [4:0]                day_r;
  logic [TW-1:0]             tot_r;
  logic [8:0]                ym400_r;
  logic                      ok_r;
  logic                      ovf_r;
  logic [DW-1:0]             wsum_r;

  logic                      out_valid_r;
  logic                      res_ok_r;
  logic                      res_ovf_r;
  logic [13:0]               res_year_r;
  logic [3:0]                res_month_r;
  logic [4:0]                res_day_r;
  logic [2:0]                res_wday_r;

  logic                      leap;
  logic [4:0]                len;
  logic                      more;
  logic                      bad;
  logic                      put;
  logic                      div_start;
  logic [DW-1:0]             div_dvd;
  logic [cdad_pkg::DV_W-1:0] div_dvs;
  logic [cdad_pkg::RCP_W-1:0] div_rcp;
  logic                      div_busy;
  logic [DW-1:0]             div_quo;
  logic [cdad_pkg::DV_W-1:0] div_rem;
  logic [6:0]                cent_rem;

  // leap rule on the year modulo 400
  assign leap = (ym400_r[1:0] == 2'd0) && (ym400_r != 9'd100) &&
                (ym400_r != 9'd200) && (ym400_r != 9'd300);
  assign len  = cdad_pkg::month_len(mo_r, leap);
  assign more = (tot_r > TW'(len)) && (yr_r <= LIMIT);
  assign bad  = (mo_r == 4'd0) || (mo_r > 4'd12) || (day_r == 5'd0) || (day_r > len);
  assign put  = (ctl.op == cdad_pkg::OP_PUT) && !(out_valid_r && out_stall);

  always_comb begin
    div_start = 1'b0;
    div_dvd   = wsum_r;
    div_dvs   = cdad_pkg::DIV_WEEK;
    div_rcp   = cdad_pkg::RCP_WEEK;
    unique case (ctl.op)
      cdad_pkg::OP_DIV_Y: begin
        div_start = 1'b1;
        div_dvd   = DW'(yr_r);
        div_dvs   = cdad_pkg::DIV_CYCLE;
        div_rcp   = cdad_pkg::RCP_CYCLE;
      end
      cdad_pkg::OP_DIV_Z: begin
        // january and february belong to the previous year
        div_start = 1'b1;
        div_dvd   = DW'(yr_r) + DW'(400) - DW'(mo_r <= 4'd2);
        div_dvs   = cdad_pkg::DIV_CENTURY;
        div_rcp   = cdad_pkg::RCP_CENTURY;
      end
      cdad_pkg::OP_DIV_W: begin
        div_start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  cdad_div #(
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .recip    (div_rcp),
    .busy     (div_busy),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  assign cent_rem = div_rem[6:0];

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      cdad_pkg::OP_LOAD: begin
        if (in_valid) begin
          yr_r  <= YW'(in_year);
          mo_r  <= in_month;
          day_r <= in_day;
          tot_r <= TW'(in_day) + TW'(in_days_to_add);
        end
      end
      cdad_pkg::OP_SET_M400: begin
        ym400_r <= div_rem;
      end
      cdad_pkg::OP_STEP: begin
        if (more) begin
          tot_r <= tot_r - TW'(len);
          if (mo_r == 4'd12) begin
            mo_r    <= 4'd1;
            yr_r    <= yr_r + 1'b1;
            ym400_r <= (ym400_r == 9'd399) ? 9'd0 : ym400_r + 1'b1;
          end else begin
            mo_r <= mo_r + 1'b1;
          end
        end
      end
      cdad_pkg::OP_SAT: begin
        if (yr_r > LIMIT) begin
          yr_r  <= LIMIT;
          mo_r  <= 4'd12;
          tot_r <= TW'(31);
        end
      end
      cdad_pkg::OP_WSUM: begin
        // d + month term + r + r/4 + c/4 + 5c
        wsum_r <= DW'(tot_r[4:0]) + DW'(cdad_pkg::MONTH_OFS[mo_r]) + DW'(cent_rem) +
                  DW'(cent_rem[6:2]) + (div_quo >> 2) + (div_quo << 2) + div_quo;
      end
      default: begin
      end
    endcase
  end

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r  <= 1'b0;
      ovf_r <= 1'b0;
    end else begin
      if (ctl.op == cdad_pkg::OP_LOAD) begin
        ovf_r <= 1'b0;
      end
      if (ctl.op == cdad_pkg::OP_CHECK) begin
        ok_r <= !bad;
      end
      if ((ctl.op == cdad_pkg::OP_SAT) && (yr_r > LIMIT)) begin
        ovf_r <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (put) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put) begin
      res_ok_r    <= ok_r;
      res_ovf_r   <= ok_r & ovf_r;
      res_year_r  <= ok_r ? yr_r[13:0] : 14'd0;
      res_month_r <= ok_r ? mo_r : 4'd0;
      res_day_r   <= ok_r ? tot_r[4:0] : 5'd0;
      res_wday_r  <= ok_r ? div_rem[2:0] : 3'd0;
    end
  end

  always_comb begin
    stat.div_busy = div_busy;
    stat.bad      = bad;
    stat.more     = more;
    stat.out_busy = out_valid_r && out_stall;
  end

  assign out_valid     = out_valid_r;
  assign out_valid_res = res_ok_r;
  assign out_overflow  = res_ovf_r;
  assign out_new_year  = res_year_r;
  assign out_new_month = res_month_r;
  assign out_new_day   = res_day_r;
  assign out_weekday   = res_wday_r;

  a_div_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_ovf_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_ovf_r) |-> res_ok_r)
    else $error("overflow flagged on an invalid date");

  a_bad_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_ok_r) |-> (res_year_r == 14'd0 && res_month_r == 4'd0 &&
                                    res_day_r == 5'd0 && res_wday_r == 3'd0))
    else $error("invalid date item carries nonzero fields");

  a_good_date: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_ok_r) |-> (res_month_r != 4'd0 && res_month_r <= 4'd12 &&
                                   res_day_r != 5'd0 && res_wday_r != 3'd7))
    else $error("result date out of range");

endmodule

// ----- sv/calendar_date_add_days.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_add_days
// gregorian date plus a day count, with validity check and weekday
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake            payload
//   in_       input       in_valid/in_stall    year, month, day, days_to_add
//   out_      output      out_valid/out_stall  valid_res, overflow, new_year,
//                                              new_month, new_day, weekday
//
// one item at a time; a valid date's time from the idle step back to it grows
// with k, the month ends crossed (up to about 2150 for the largest day count),
// and an invalid date skips the month stepping, the century split and the
// weekday sum; the month stepping loop sets the time, and the three divisions
// by constants (leap setup, century split, weekday) each wait on the divider.
// reset is synchronous, active low, and returns the sequencer to idle.
// a finished item sits in the output register; the next item is accepted and
// worked on while it waits, stalling only at the final write-back step.
//
module calendar_date_add_days #(
  parameter int YEAR_LIMIT = cdad_pkg::YEAR_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [13:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  input  logic [15:0] in_days_to_add,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_valid_res,
  output logic        out_overflow,
  output logic [13:0] out_new_year,
  output logic [3:0]  out_new_month,
  output logic [4:0]  out_new_day,
  output logic [2:0]  out_weekday
);

  cdad_pkg::ctl_t  ctl;
  cdad_pkg::stat_t stat;

  // items only enter at the idle step of the program
  assign in_stall = !ctl.idle;

  // program counter and control rom
  cdad_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .ctl      (ctl)
  );

  // date registers, divider and output stage
  cdad_dp #(
    .YEAR_LIMIT (YEAR_LIMIT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .stat           (stat),
    .in_valid       (in_valid),
    .in_year        (in_year),
    .in_month       (in_month),
    .in_day         (in_day),
    .in_days_to_add (in_days_to_add),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_valid_res  (out_valid_res),
    .out_overflow   (out_overflow),
    .out_new_year   (out_new_year),
    .out_new_month  (out_new_month),
    .out_new_day    (out_new_day),
    .out_weekday    (out_weekday)
  );

endmodule
